/* hw/rtl/assert_macros.svh */
// Assertion helpers for the fan controller checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/fsc_pkg.sv */
package fsc_pkg;

	localparam int TICKS_PER_PERIOD = 50;
	localparam int DIGIT_COUNT      = 6;
	localparam int TICK_W           = $clog2(TICKS_PER_PERIOD);
	localparam int DIGIT_W          = $clog2(DIGIT_COUNT);
	localparam int SAMPLE_W         = 12;
	localparam int SPEED_W          = 7;
	localparam int SEL_W            = 6;
	localparam int CMP_W            = (TICK_W + 1 > SPEED_W) ? TICK_W + 1 : SPEED_W;
	localparam int CFG_DATA_W       = 12;
	localparam int REG_IDX_W        = 2;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
	localparam logic [3:0] BLANK_CODE = 4'd10;

	typedef logic [3:0] fsc_code_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOW_THRESHOLD  = 2'd0,
		REG_HIGH_THRESHOLD = 2'd1,
		REG_MANUAL_STEP    = 2'd2
	} fsc_reg_t;

	typedef enum logic [2:0] {
		DISP_SPEED  = 3'd0,
		DISP_TEMP   = 3'd1,
		DISP_HOLD_1 = 3'd2,
		DISP_HOLD_2 = 3'd3,
		DISP_HOLD_3 = 3'd4
	} fsc_disp_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] adc_sample;
		logic                auto_mode;
		logic                up_button;
		logic                down_button;
	} fsc_in_t;

	typedef struct packed {
		logic       fan_pwm;
		logic [7:0] segments_n;
		logic [5:0] digit_select;
	} fsc_out_t;

	typedef struct packed {
		fsc_code_t whole_tens;
		fsc_code_t whole_units;
		fsc_code_t frac_tens;
		fsc_code_t frac_units;
	} fsc_temp_t;

	typedef struct packed {
		fsc_in_t   item;
		fsc_temp_t temp;
	} fsc_job_t;

	// exact floor(x/10) for x < 512
	function automatic logic [5:0] div10(input logic [8:0] x);
		logic [16:0] p;
		p = 17'(x) * 17'd205;
		return p[16:11];
	endfunction

	// segments a..g, active high
	function automatic logic [7:0] seg_pattern(input fsc_code_t code);
		logic [7:0] s;
		case (code)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/fsc_temp_pipe.sv */
module fsc_temp_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  fsc_pkg::fsc_in_t  tick,
	output logic              job_valid,
	input  logic              job_ready,
	output fsc_pkg::fsc_job_t job
);
	import fsc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	fsc_in_t     item_s1, item_s2, item_s3, item_s4;
	logic [15:0] frac_raw_s2, frac_raw_s3;
	logic [8:0]  whole_s2;
	logic [8:0]  frac_q100_s3;
	fsc_code_t   whole_tens_s3, whole_units_s3;
	fsc_temp_t   temp_s4;

	logic [20:0] whole_prod;
	logic [23:0] frac_prod;
	logic [31:0] q100_prod;
	logic [5:0]  whole_div, whole_div2, whole_tens_w;
	logic [8:0]  whole_units_w;
	logic [15:0] frac_w;
	logic [5:0]  frac_div;
	logic [6:0]  frac_units_w;
	fsc_temp_t   temp_w;

	assign ready_s4   = !valid_s4 || job_ready;
	assign ready_s3   = !valid_s3 || ready_s4;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign tick_ready = ready_s1;
	assign job_valid  = valid_s4;
	assign job.item   = item_s4;
	assign job.temp   = temp_s4;

	// whole = sample*500/4096, raw = sample*3125/256
	always_comb begin
		whole_prod = 21'(item_s1.adc_sample) * 21'd500;
		frac_prod  = 24'(item_s1.adc_sample) * 24'd3125;
	end

	// raw/100 by reciprocal, whole digits
	always_comb begin
		q100_prod     = 32'(frac_raw_s2) * 32'd83887;
		whole_div     = div10(whole_s2);
		whole_div2    = div10(9'(whole_div));
		whole_tens_w  = whole_div - 6'(whole_div2 * 6'd10);
		whole_units_w = whole_s2 - 9'(whole_div) * 9'd10;
	end

	// frac = raw mod 100, split into digits
	always_comb begin
		frac_w           = frac_raw_s3 - 16'(frac_q100_s3) * 16'd100;
		frac_div         = div10(9'(frac_w[6:0]));
		frac_units_w     = frac_w[6:0] - 7'(frac_div) * 7'd10;
		temp_w.whole_tens  = whole_tens_s3;
		temp_w.whole_units = whole_units_s3;
		temp_w.frac_tens   = frac_div[3:0];
		temp_w.frac_units  = frac_units_w[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= tick_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			item_s1 <= tick;
		end
		if (ready_s2) begin
			item_s2     <= item_s1;
			whole_s2    <= whole_prod[20:12];
			frac_raw_s2 <= frac_prod[23:8];
		end
		if (ready_s3) begin
			item_s3        <= item_s2;
			frac_raw_s3    <= frac_raw_s2;
			frac_q100_s3   <= q100_prod[31:23];
			whole_tens_s3  <= whole_tens_w[3:0];
			whole_units_s3 <= whole_units_w[3:0];
		end
		if (ready_s4) begin
			item_s4 <= item_s3;
			temp_s4 <= temp_w;
		end
	end

endmodule

/* hw/rtl/fsc_core.sv */
module fsc_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fsc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [fsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  fsc_pkg::fsc_job_t                job,
	output logic                             status_valid,
	input  logic                             status_ready,
	output fsc_pkg::fsc_out_t                status
);
	import fsc_pkg::*;

	logic [SAMPLE_W-1:0] low_thr_q, high_thr_q, latched_q;
	logic [SPEED_W-1:0]  step_q, speed_q;
	logic [TICK_W-1:0]   tick_q;
	logic                sample_phase_q, dot_q, up_latch_q, down_latch_q;
	fsc_disp_t           phase_q;
	logic [DIGIT_W-1:0]  digit_idx_q;
	fsc_code_t           codes_q [DIGIT_COUNT];
	logic                out_valid_q;
	fsc_out_t            out_q;

	logic                accept;
	logic [SAMPLE_W-1:0] latched_d, diff;
	logic [17:0]         div3_prod;
	logic [SPEED_W-1:0]  auto_speed, manual_speed, speed_d;
	logic                up_edge, down_edge, up_latch_d, down_latch_d;
	logic signed [8:0]   manual_sum;
	logic [TICK_W:0]     tick_sum;
	logic                wrap;
	logic [TICK_W-1:0]   tick_d;
	fsc_disp_t           phase_next, phase_d;
	logic [5:0]          spd_div;
	logic [SPEED_W-1:0]  spd_units;
	fsc_code_t           codes_d [DIGIT_COUNT];
	logic                dot_d;
	fsc_code_t           cur_code;
	fsc_out_t            out_d;
	logic [DIGIT_W-1:0]  digit_idx_d;

	assign job_ready    = !out_valid_q || status_ready;
	assign accept       = job_valid && job_ready;
	assign status_valid = out_valid_q;
	assign status       = out_q;

	// speed update
	always_comb begin
		latched_d  = sample_phase_q ? latched_q : job.item.adc_sample;
		diff       = latched_d - low_thr_q;
		div3_prod  = 18'({diff[7:0], 1'b0}) * 18'd683;
		if (latched_d > high_thr_q) begin
			auto_speed = SPEED_MAX;
		end else if (latched_d > low_thr_q) begin
			if (diff >= 12'd150) auto_speed = SPEED_MAX;
			else auto_speed = div3_prod[17:11];
		end else begin
			auto_speed = '0;
		end

		up_edge    = !job.item.auto_mode && job.item.up_button && !up_latch_q;
		down_edge  = !job.item.auto_mode && job.item.down_button && !down_latch_q;
		manual_sum = $signed({2'b00, speed_q})
			+ (up_edge ? $signed({2'b00, step_q}) : 9'sd0)
			- (down_edge ? $signed({2'b00, step_q}) : 9'sd0);
		if (manual_sum < 9'sd0) manual_speed = '0;
		else if (manual_sum > 9'sd100) manual_speed = SPEED_MAX;
		else manual_speed = manual_sum[SPEED_W-1:0];

		speed_d      = job.item.auto_mode ? auto_speed : manual_speed;
		up_latch_d   = job.item.up_button && (up_latch_q || !job.item.auto_mode);
		down_latch_d = job.item.down_button && (down_latch_q || !job.item.auto_mode);
	end

	// display phase, next state
	always_comb begin
		case (phase_q)
			DISP_SPEED:  phase_next = DISP_TEMP;
			DISP_TEMP:   phase_next = DISP_HOLD_1;
			DISP_HOLD_1: phase_next = DISP_HOLD_2;
			DISP_HOLD_2: phase_next = DISP_HOLD_3;
			DISP_HOLD_3: phase_next = DISP_SPEED;
			default:     phase_next = DISP_SPEED;
		endcase
	end

	// tick counter and digit buffer
	always_comb begin
		tick_sum = {1'b0, tick_q} + 1'b1;
		wrap     = tick_sum >= (TICK_W+1)'(TICKS_PER_PERIOD);
		tick_d   = wrap ? '0 : tick_sum[TICK_W-1:0];
		phase_d  = wrap ? phase_next : phase_q;

		spd_div   = div10(9'(speed_d));
		spd_units = speed_d - 7'(spd_div) * 7'd10;

		dot_d = dot_q;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			codes_d[i] = wrap ? BLANK_CODE : codes_q[i];
		end
		if (wrap) begin
			case (phase_d)
				DISP_SPEED: begin
					codes_d[0] = (speed_d == SPEED_MAX) ? 4'd1 : 4'd0;
					codes_d[1] = (spd_div == 6'd10) ? 4'd0 : spd_div[3:0];
					codes_d[2] = spd_units[3:0];
					dot_d      = 1'b0;
				end
				DISP_TEMP: begin
					codes_d[0] = job.temp.whole_tens;
					codes_d[1] = job.temp.whole_units;
					codes_d[2] = job.temp.frac_tens;
					codes_d[3] = job.temp.frac_units;
					dot_d      = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result
	always_comb begin
		cur_code         = codes_d[digit_idx_q];
		out_d.segments_n = ~seg_pattern(cur_code);
		if (dot_d && digit_idx_q == DIGIT_W'(1)) out_d.segments_n[7] = 1'b0;
		for (int j = 0; j < SEL_W; j++) begin
			out_d.digit_select[j] = (j < DIGIT_COUNT) && (digit_idx_q == DIGIT_W'(j));
		end
		out_d.fan_pwm = CMP_W'({tick_d, 1'b0}) < CMP_W'(speed_d);
		digit_idx_d   = (digit_idx_q == DIGIT_W'(DIGIT_COUNT - 1)) ? '0 : digit_idx_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= 12'd150;
			high_thr_q <= 12'd300;
			step_q     <= 7'd5;
		end else if (cfg_we) begin
			case (fsc_reg_t'(cfg_index))
				REG_LOW_THRESHOLD:  low_thr_q  <= cfg_data;
				REG_HIGH_THRESHOLD: high_thr_q <= cfg_data;
				REG_MANUAL_STEP:    step_q     <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q      <= '0;
			speed_q        <= '0;
			tick_q         <= '0;
			sample_phase_q <= 1'b0;
			dot_q          <= 1'b0;
			up_latch_q     <= 1'b0;
			down_latch_q   <= 1'b0;
			phase_q        <= DISP_SPEED;
			digit_idx_q    <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) codes_q[i] <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (job_ready) out_valid_q <= job_valid;
			if (accept) begin
				latched_q      <= latched_d;
				speed_q        <= speed_d;
				tick_q         <= tick_d;
				sample_phase_q <= sample_phase_q ^ wrap;
				dot_q          <= dot_d;
				up_latch_q     <= up_latch_d;
				down_latch_q   <= down_latch_d;
				phase_q        <= phase_d;
				digit_idx_q    <= digit_idx_d;
				for (int i = 0; i < DIGIT_COUNT; i++) codes_q[i] <= codes_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) out_q <= out_d;
	end

endmodule

/* hw/rtl/fan_speed_controller_with_display_unit.sv */
// Fan speed controller with a six-digit multiplexed seven-segment display. Each transfer
// on the tick channel is one timer tick and yields exactly one transfer on the status
// channel (motor PWM bit, active-low segments, one-hot digit enable). A tick is taken
// every cycle while the status side keeps up; each tick passes through the four-stage
// temperature-to-digit pipeline and then the state and result registers. Threshold and
// step registers are written through the cfg port; the user must write them only while
// no tick is in flight, as the block itself does not enforce this.
module fan_speed_controller_with_display_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fsc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           tick_valid,
	output logic                           tick_ready,
	input  fsc_pkg::fsc_in_t               tick,
	output logic                           status_valid,
	input  logic                           status_ready,
	output fsc_pkg::fsc_out_t              status
);
	import fsc_pkg::*;

	logic     job_valid, job_ready;
	fsc_job_t job;

	fsc_temp_pipe u_temp_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	fsc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (job),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status       (status)
	);

endmodule

/* hw/rtl/fsc_checker.sv */
`include "assert_macros.svh"

module fsc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              status_valid,
	input logic              status_ready,
	input fsc_pkg::fsc_out_t status
);
	import fsc_pkg::*;

	logic             seen_q;
	logic [SEL_W-1:0] last_sel_q;
	logic [SEL_W-1:0] expect_sel;
	logic             out_xfer;

	assign out_xfer   = status_valid && status_ready;
	assign expect_sel = {last_sel_q[SEL_W-2:0], last_sel_q[SEL_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_sel_q <= '0;
		end else if (out_xfer) begin
			seen_q     <= 1'b1;
			last_sel_q <= status.digit_select;
		end
	end

	`FSC_ASSERT_IMPL(a_sel_onehot, clk, arst_n, status_valid, $onehot(status.digit_select), "digit enable not one-hot")
	`FSC_ASSERT_IMPL(a_sel_rotates, clk, arst_n, out_xfer && seen_q, status.digit_select == expect_sel, "digit scan skipped or repeated")
	`FSC_ASSERT_IMPL(a_dot_digit1, clk, arst_n, status_valid && !status.segments_n[7], status.digit_select == 6'b000010, "decimal point off digit 1")
	`FSC_ASSERT_NEXT(a_status_hold, clk, arst_n, status_valid && !status_ready, status_valid && $stable(status), "stalled status changed")

endmodule

bind fan_speed_controller_with_display_unit fsc_checker u_fsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.status_valid (status_valid),
	.status_ready (status_ready),
	.status       (status)
);

/* dv/fsc_checker.sv */
module fsc_tb_checker import fsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  tick_valid,
	input  logic                  tick_ready,
	input  fsc_in_t               tick,
	input  logic                  status_valid,
	input  logic                  status_ready,
	input  fsc_out_t              status,
	output int                    fail_count,
	output int                    in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [SAMPLE_W-1:0] low_thr, high_thr, held_sample;
	logic [SPEED_W-1:0]  step_size;
	int                  tick_pos, scan_pos, speed;
	logic                sample_hold, dp_on, up_held, down_held;
	fsc_disp_t           disp_phase;
	fsc_code_t           digits [DIGIT_COUNT];

	fsc_out_t status_q [$];
	int       ticks_seen, results_seen;
	int       n_fail = 0;

	assign fail_count = n_fail;
	assign in_flight  = ticks_seen - results_seen;

	function automatic logic [7:0] lit_segments(input fsc_code_t c);
		case (c)
			4'd0: return 8'h3F;
			4'd1: return 8'h06;
			4'd2: return 8'h5B;
			4'd3: return 8'h4F;
			4'd4: return 8'h66;
			4'd5: return 8'h6D;
			4'd6: return 8'h7D;
			4'd7: return 8'h07;
			4'd8: return 8'h7F;
			4'd9: return 8'h6F;
			default: return 8'h00;
		endcase
	endfunction

	function automatic void set_digit(input int pos, input int code);
		if (pos < DIGIT_COUNT)
			digits[pos] = 4'(code);
	endfunction

	function automatic void reload_digits(input logic [SAMPLE_W-1:0] s);
		int whole, frac;
		for (int i = 0; i < DIGIT_COUNT; i++)
			digits[i] = BLANK_CODE;
		if (disp_phase == DISP_SPEED) begin
			set_digit(0, (speed / 100) % 10);
			set_digit(1, (speed / 10) % 10);
			set_digit(2, speed % 10);
			dp_on = 1'b0;
		end else if (disp_phase == DISP_TEMP) begin
			whole = int'(s) * 500 / 4096;
			frac  = (int'(s) * 3125 / 256) % 100;
			set_digit(0, (whole / 10) % 10);
			set_digit(1, whole % 10);
			set_digit(2, frac / 10);
			set_digit(3, frac % 10);
			dp_on = 1'b1;
		end
	endfunction

	function automatic fsc_out_t predict_status(input fsc_in_t t);
		fsc_out_t r;
		int       pos;
		if (!sample_hold)
			held_sample = t.adc_sample;
		if (t.auto_mode) begin
			if (held_sample > high_thr)
				speed = 100;
			else if (held_sample > low_thr)
				speed = (int'(held_sample) - int'(low_thr)) * 2 / 3;
			else
				speed = 0;
		end else begin
			if (t.up_button && !up_held) begin
				up_held = 1'b1;
				speed += int'(step_size);
			end
			if (t.down_button && !down_held) begin
				down_held = 1'b1;
				speed -= int'(step_size);
			end
		end
		if (!t.up_button)
			up_held = 1'b0;
		if (!t.down_button)
			down_held = 1'b0;
		if (speed > 100)
			speed = 100;
		if (speed < 0)
			speed = 0;

		tick_pos++;
		if (tick_pos >= TICKS_PER_PERIOD) begin
			tick_pos    = 0;
			sample_hold = !sample_hold;
			disp_phase  = (disp_phase == DISP_HOLD_3) ? DISP_SPEED : fsc_disp_t'(disp_phase + 1);
			reload_digits(t.adc_sample);
		end

		pos = scan_pos % DIGIT_COUNT;
		r.segments_n = ~lit_segments(digits[pos]);
		if (dp_on && pos == 1)
			r.segments_n[7] = 1'b0;
		r.digit_select = 6'(32'd1 << pos);
		scan_pos = (pos + 1) % DIGIT_COUNT;
		r.fan_pwm = (tick_pos * 2 < speed);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned want_v, got_v);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		fsc_out_t want;
		if (!arst_n) begin
			low_thr     = 12'd150;
			high_thr    = 12'd300;
			step_size   = 7'd5;
			held_sample = '0;
			tick_pos    = 0;
			scan_pos    = 0;
			speed       = 0;
			sample_hold = 1'b0;
			dp_on       = 1'b0;
			up_held     = 1'b0;
			down_held   = 1'b0;
			disp_phase  = DISP_SPEED;
			for (int i = 0; i < DIGIT_COUNT; i++)
				digits[i] = '0;
			status_q.delete();
			ticks_seen   <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (fsc_reg_t'(cfg_index))
					REG_LOW_THRESHOLD: low_thr = cfg_data[SAMPLE_W-1:0];
					REG_HIGH_THRESHOLD: high_thr = cfg_data[SAMPLE_W-1:0];
					REG_MANUAL_STEP: step_size = cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (tick_valid && tick_ready) begin
				status_q.push_back(predict_status(tick));
				ticks_seen <= ticks_seen + 1;
			end
			if (status_valid && status_ready) begin
				results_seen <= results_seen + 1;
				if (status_q.size() == 0) begin
					flag_mismatch("unexpected status", 32'd0, 32'(status));
				end else begin
					want = status_q.pop_front();
					if (status.fan_pwm !== want.fan_pwm)
						flag_mismatch("fan_pwm", 32'(want.fan_pwm), 32'(status.fan_pwm));
					if (status.segments_n !== want.segments_n)
						flag_mismatch("segments_n", 32'(want.segments_n),
							32'(status.segments_n));
					if (status.digit_select !== want.digit_select)
						flag_mismatch("digit_select", 32'(want.digit_select),
							32'(status.digit_select));
				end
			end
		end
	end

endmodule

/* dv/tb_fan_speed_controller_with_display_unit.sv */
module tb_fan_speed_controller_with_display_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import fsc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AFTER  = 300;
	localparam int HOLD_CYCLES = 250;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  tick_valid   = 1'b0;
	logic                  tick_ready;
	fsc_in_t               tick         = '0;
	logic                  status_valid;
	logic                  status_ready = 1'b0;
	fsc_out_t              status;

	int   fail_count, in_flight;
	int   quiet_cycles = 0;
	logic idle_on      = 1'b1;
	logic up_lvl       = 1'b0;
	logic down_lvl     = 1'b0;
	logic [SAMPLE_W-1:0] cur_lo = 12'd150;
	logic [SAMPLE_W-1:0] cur_hi = 12'd300;

	fan_speed_controller_with_display_unit u_top (.*);

	fsc_tb_checker u_check (.*);

	always #5ns clk = ~clk;

	// stall watchdog: any transfer or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (tick_valid && tick_ready) || (status_valid && status_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("fan_speed_controller_with_display_unit test failed");
			$finish;
		end
	end

	// status sink: random back-pressure plus one long hold so the block fills up
	initial begin : status_sink
		int unsigned taken;
		bit          held;
		taken = 0;
		held  = 0;
		wait (arst_n);
		forever begin
			if (!held && taken >= HOLD_AFTER) begin
				held = 1;
				status_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				status_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			status_ready <= 1'b1;
			@(posedge clk);
			if (status_valid && status_ready)
				taken++;
		end
	end

	function automatic fsc_in_t mk(input logic [SAMPLE_W-1:0] s, input logic a, u, d);
		fsc_in_t t;
		t.adc_sample  = s;
		t.auto_mode   = a;
		t.up_button   = u;
		t.down_button = d;
		return t;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 3))
			0: v = int'(cur_lo) + int'($urandom_range(0, 16)) - 8;
			1: v = int'(cur_hi) + int'($urandom_range(0, 16)) - 8;
			2: v = int'($urandom_range(cur_lo, cur_hi));
			default: v = int'($urandom_range(0, 4095));
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	task automatic put_tick(input fsc_in_t t);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= t;
		@(posedge clk);
		while (!tick_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	task automatic set_regs(input logic [SAMPLE_W-1:0] lo, hi, input logic [SPEED_W-1:0] st);
		drain();
		cur_lo = lo;
		cur_hi = hi;
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOW_THRESHOLD;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_HIGH_THRESHOLD;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_MANUAL_STEP;
		cfg_data  <= CFG_DATA_W'(st);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// a non-noisy run holds one mode and holds and releases buttons over several ticks; a noisy run randomises every field
	task automatic send_run(input int len);
		fsc_in_t t;
		logic    run_auto;
		bit      noisy;
		run_auto = 1'($urandom_range(0, 1));
		noisy    = ($urandom_range(0, 9) == 0);
		repeat (len) begin
			if (noisy) begin
				t.adc_sample  = 12'($urandom);
				t.auto_mode   = 1'($urandom);
				t.up_button   = 1'($urandom);
				t.down_button = 1'($urandom);
			end else begin
				if ($urandom_range(0, 2) == 0)
					up_lvl = !up_lvl;
				if ($urandom_range(0, 2) == 0)
					down_lvl = !down_lvl;
				t = mk(pick_sample(), run_auto, up_lvl, down_lvl);
			end
			put_tick(t);
		end
	endtask

	task automatic random_phase(input int n);
		int done, len;
		done = 0;
		while (done < n) begin
			len = $urandom_range(20, 80);
			send_run(len);
			done += len;
		end
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// thresholds at reset values: auto edges, then manual presses and clamps
		put_tick(mk(12'd0, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd4095, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd150, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd151, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd300, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd301, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'hAAA, 1'b0, 1'b1, 1'b0));
		put_tick(mk(12'h555, 1'b0, 1'b1, 1'b1));
		put_tick(mk(12'd0, 1'b0, 1'b0, 1'b1));
		put_tick(mk(12'd0, 1'b0, 1'b1, 1'b0));
		put_tick(mk(12'd0, 1'b0, 1'b0, 1'b0));
		put_tick(mk(12'd0, 1'b0, 1'b0, 1'b1));

		// swapped thresholds, largest step
		set_regs(12'd4095, 12'd0, 7'd100);
		put_tick(mk(12'd4095, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd0, 1'b1, 1'b1, 1'b1));
		put_tick(mk(12'd0, 1'b0, 1'b1, 1'b0));
		put_tick(mk(12'd0, 1'b0, 1'b0, 1'b1));
		put_tick(mk(12'd0, 1'b0, 1'b1, 1'b1));

		// widest window, zero step
		set_regs(12'd0, 12'd4095, 7'd0);
		put_tick(mk(12'd4095, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd3, 1'b1, 1'b0, 1'b0));
		put_tick(mk(12'd0, 1'b0, 1'b1, 1'b0));
		put_tick(mk(12'd0, 1'b0, 1'b0, 1'b1));

		set_regs(12'd150, 12'd300, 7'd5);
		random_phase(400);
		set_regs(12'd0, 12'd4095, 7'd100);
		random_phase(400);
		set_regs(12'd4095, 12'd0, 7'd0);
		random_phase(400);
		set_regs(12'($urandom), 12'($urandom), 7'($urandom_range(0, 100)));
		random_phase(400);
		set_regs(12'd100, 12'd250, 7'd7);
		idle_on <= 1'b0;
		random_phase(400);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("fan_speed_controller_with_display_unit test passed");
		else
			$display("fan_speed_controller_with_display_unit test failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_temp_pipe.sv
hw/rtl/fsc_core.sv
hw/rtl/fan_speed_controller_with_display_unit.sv
hw/rtl/fsc_checker.sv
dv/fsc_checker.sv
dv/tb_fan_speed_controller_with_display_unit.sv
